// ===== rtl/wav_riff_stream_parser_core_macros.svh =====
// Assertion shorthands shared by the parser RTL.
`ifndef WAV_RIFF_STREAM_PARSER_CORE_MACROS_SVH
`define WAV_RIFF_STREAM_PARSER_CORE_MACROS_SVH

// Condition that must hold at every enabled clock edge.
`define WRSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition at one edge that must be followed by another at the next edge.
`define WRSP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/wrsp_pkg.sv =====
`default_nettype none
package wrsp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
   localparam int unsigned TAG_BYTES    = 4;
   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned MAX_SAMPLE_BYTES = 4;

   localparam int unsigned RSP_DATA_W = 112;

   typedef enum logic [8:0] {
      PH_RIFF_TAG  = 9'b000000001,
      PH_RIFF_SIZE = 9'b000000010,
      PH_WAVE_TAG  = 9'b000000100,
      PH_HEADER    = 9'b000001000,
      PH_FMT       = 9'b000010000,
      PH_SKIP      = 9'b000100000,
      PH_PAD       = 9'b001000000,
      PH_DATA      = 9'b010000000,
      PH_DONE      = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_FORMAT = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_ERROR  = 2'd2
   } out_kind_type;

   typedef enum logic [2:0] {
      ERR_NOT_RIFF     = 3'd0,
      ERR_NOT_WAVE     = 3'd1,
      ERR_FMT_SMALL    = 3'd2,
      ERR_FMT_MISSING  = 3'd3,
      ERR_DATA_MISSING = 3'd4,
      ERR_SAMPLE_SIZE  = 3'd5
   } err_code_type;

   localparam logic IN_KIND_BYTE = 1'b0;
   localparam logic IN_KIND_EOF  = 1'b1;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [12:0] bytes_per_sample;
      logic [15:0] channel_index;
      logic [31:0] sample_value;
      logic [2:0]  error_code;
      logic        is_last;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== rtl/wrsp_parser.sv =====
`default_nettype none
`include "wav_riff_stream_parser_core_macros.svh"
module wrsp_parser
   import wrsp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  wire logic         item_kind,
   input  wire logic [7:0]   item_byte,
   output logic              res_valid,
   output rsp_item_type      res_item
);

   phase_type    phase_ff, phase_in;
   logic [31:0]  pos_ff, pos_in;
   logic [31:0]  tag_ff, tag_in;
   logic [31:0]  len_ff, len_in;
   logic         fmt_seen_ff, fmt_seen_in;
   logic [15:0]  chan_ff, chan_in;
   logic [31:0]  rate_ff, rate_in;
   logic [12:0]  bps_ff, bps_in;
   logic [28:0]  frame_ff, frame_in;
   logic [31:0]  acc_ff, acc_in;
   logic [2:0]   bis_ff, bis_in;
   logic [15:0]  cur_ch_ff, cur_ch_in;
   logic [31:0]  rem_ff, rem_in;

   logic [31:0]  pos_nx;
   logic [31:0]  len_nx;
   logic [31:0]  acc_nx;
   logic [2:0]   bis_nx;
   logic [31:0]  rem_nx;
   logic [16:0]  ch_nx;

   // frame size only changes inside fmt bodies; the product is registered in frame_ff
   // but always settled before the next chunk header completes
   assign frame_in = 29'(chan_ff) * 29'(bps_ff);

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      tag_in      = tag_ff;
      len_in      = len_ff;
      fmt_seen_in = fmt_seen_ff;
      chan_in     = chan_ff;
      rate_in     = rate_ff;
      bps_in      = bps_ff;
      acc_in      = acc_ff;
      bis_in      = bis_ff;
      cur_ch_in   = cur_ch_ff;
      rem_in      = rem_ff;
      res_valid   = 1'b0;
      res_item    = '0;

      pos_nx = pos_ff + 32'd1;
      len_nx = len_ff;
      acc_nx = acc_ff | (32'(item_byte) << {bis_ff[1:0], 3'b000});
      bis_nx = bis_ff + 3'd1;
      rem_nx = rem_ff - 32'd1;
      ch_nx  = {1'b0, cur_ch_ff} + 17'd1;

      if (item_valid && phase_ff != PH_DONE) begin
         if (item_kind == IN_KIND_EOF) begin
            case (phase_ff)
               PH_RIFF_TAG: begin
                  res_valid           = 1'b1;
                  res_item.out_kind   = KIND_ERROR;
                  res_item.error_code = ERR_NOT_RIFF;
               end
               PH_RIFF_SIZE, PH_WAVE_TAG: begin
                  res_valid           = 1'b1;
                  res_item.out_kind   = KIND_ERROR;
                  res_item.error_code = ERR_NOT_WAVE;
               end
               PH_HEADER, PH_FMT, PH_SKIP, PH_PAD: begin
                  res_valid           = 1'b1;
                  res_item.out_kind   = KIND_ERROR;
                  res_item.error_code = ERR_DATA_MISSING;
               end
               default: ;
            endcase
            phase_in = PH_DONE;
         end else begin
            case (phase_ff)
               PH_RIFF_TAG, PH_WAVE_TAG: begin
                  tag_in = {tag_ff[23:0], item_byte};
                  pos_in = pos_nx;
                  if (pos_nx >= 32'(TAG_BYTES)) begin
                     pos_in = '0;
                     if (phase_ff == PH_RIFF_TAG && tag_in != TAG_RIFF) begin
                        res_valid           = 1'b1;
                        res_item.out_kind   = KIND_ERROR;
                        res_item.error_code = ERR_NOT_RIFF;
                        phase_in            = PH_DONE;
                     end else if (phase_ff == PH_WAVE_TAG && tag_in != TAG_WAVE) begin
                        res_valid           = 1'b1;
                        res_item.out_kind   = KIND_ERROR;
                        res_item.error_code = ERR_NOT_WAVE;
                        phase_in            = PH_DONE;
                     end else begin
                        phase_in = (phase_ff == PH_RIFF_TAG) ? PH_RIFF_SIZE : PH_HEADER;
                        tag_in   = '0;
                     end
                  end
               end
               PH_RIFF_SIZE: begin
                  pos_in = pos_nx;
                  if (pos_nx >= 32'(TAG_BYTES)) begin
                     pos_in   = '0;
                     phase_in = PH_WAVE_TAG;
                  end
               end
               PH_HEADER: begin
                  if (pos_ff < 32'(TAG_BYTES)) begin
                     tag_in = {tag_ff[23:0], item_byte};
                  end else if (pos_ff == 32'(TAG_BYTES)) begin
                     len_nx = 32'(item_byte);
                  end else begin
                     len_nx = len_ff | (32'(item_byte) << {pos_ff[1:0], 3'b000});
                  end
                  len_in = len_nx;
                  pos_in = pos_nx;
                  if (pos_nx >= 32'(HEADER_BYTES)) begin
                     // header complete: pick the chunk handler
                     pos_in = '0;
                     if (tag_ff == TAG_FMT) begin
                        if (len_nx < FMT_MIN_LEN) begin
                           res_valid           = 1'b1;
                           res_item.out_kind   = KIND_ERROR;
                           res_item.error_code = ERR_FMT_SMALL;
                           phase_in            = PH_DONE;
                        end else begin
                           phase_in = PH_FMT;
                        end
                     end else if (tag_ff == TAG_DATA) begin
                        if (!fmt_seen_ff) begin
                           res_valid           = 1'b1;
                           res_item.out_kind   = KIND_ERROR;
                           res_item.error_code = ERR_FMT_MISSING;
                           phase_in            = PH_DONE;
                        end else if (bps_ff == '0 ||
                                     bps_ff > 13'(MAX_SAMPLE_BYTES)) begin
                           res_valid           = 1'b1;
                           res_item.out_kind   = KIND_ERROR;
                           res_item.error_code = ERR_SAMPLE_SIZE;
                           phase_in            = PH_DONE;
                        end else begin
                           rem_in    = len_nx;
                           acc_in    = '0;
                           bis_in    = '0;
                           cur_ch_in = '0;
                           phase_in  = (frame_ff == '0 || len_nx < 32'(frame_ff)) ?
                                       PH_DONE : PH_DATA;
                           res_valid                 = 1'b1;
                           res_item.out_kind         = KIND_FORMAT;
                           res_item.channel_count    = chan_ff;
                           res_item.sample_rate      = rate_ff;
                           res_item.bytes_per_sample = bps_ff;
                        end
                     end else if (len_nx == '0) begin
                        phase_in = PH_HEADER;
                        tag_in   = '0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_FMT: begin
                  if (pos_ff == 32'd2) begin
                     chan_in = 16'(item_byte);
                  end else if (pos_ff == 32'd3) begin
                     chan_in = chan_ff | {item_byte, 8'h00};
                  end else if (pos_ff == 32'd4) begin
                     rate_in = 32'(item_byte);
                  end else if (pos_ff >= 32'd5 && pos_ff <= 32'd7) begin
                     rate_in = rate_ff | (32'(item_byte) << {pos_ff[1:0], 3'b000});
                  end else if (pos_ff == 32'd14) begin
                     bps_in = 13'(item_byte >> 3);   // bits to bytes
                  end else if (pos_ff == 32'd15) begin
                     bps_in = bps_ff | {item_byte, 5'b00000};
                  end
                  pos_in = pos_nx;
                  if (pos_nx == len_ff) begin
                     fmt_seen_in = 1'b1;
                     phase_in    = len_ff[0] ? PH_PAD : PH_HEADER;
                     pos_in      = '0;
                     tag_in      = '0;
                  end
               end
               PH_SKIP: begin
                  pos_in = pos_nx;
                  if (pos_nx == len_ff) begin
                     phase_in = len_ff[0] ? PH_PAD : PH_HEADER;
                     pos_in   = '0;
                     tag_in   = '0;
                  end
               end
               PH_PAD: begin
                  phase_in = PH_HEADER;
                  pos_in   = '0;
                  tag_in   = '0;
               end
               PH_DATA: begin
                  acc_in = acc_nx;
                  bis_in = bis_nx;
                  rem_in = rem_nx;
                  if (13'(bis_nx) >= bps_ff) begin
                     acc_in                 = '0;
                     bis_in                 = '0;
                     res_valid              = 1'b1;
                     res_item.out_kind      = KIND_SAMPLE;
                     res_item.channel_index = cur_ch_ff;
                     res_item.sample_value  = acc_nx;
                     if (ch_nx >= {1'b0, chan_ff}) begin
                        cur_ch_in = '0;
                        if (rem_nx < 32'(frame_ff)) begin
                           res_item.is_last = 1'b1;
                           phase_in         = PH_DONE;
                        end
                     end else begin
                        cur_ch_in = ch_nx[15:0];
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF_TAG;
         pos_ff      <= '0;
         tag_ff      <= '0;
         len_ff      <= '0;
         fmt_seen_ff <= 1'b0;
         chan_ff     <= '0;
         rate_ff     <= '0;
         bps_ff      <= '0;
         frame_ff    <= '0;
         acc_ff      <= '0;
         bis_ff      <= '0;
         cur_ch_ff   <= '0;
         rem_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         tag_ff      <= tag_in;
         len_ff      <= len_in;
         fmt_seen_ff <= fmt_seen_in;
         chan_ff     <= chan_in;
         rate_ff     <= rate_in;
         bps_ff      <= bps_in;
         frame_ff    <= frame_in;
         acc_ff      <= acc_in;
         bis_ff      <= bis_in;
         cur_ch_ff   <= cur_ch_in;
         rem_ff      <= rem_in;
      end
   end

   `WRSP_ASSERT(a_res_needs_item, clock, reset, !res_valid || item_valid, "result without item")
   `WRSP_ASSERT_NEXT(a_done_sticks, clock, reset, phase_ff == PH_DONE, phase_ff == PH_DONE, "left done")
   `WRSP_ASSERT(a_bis_in_range, clock, reset, (phase_ff != PH_DATA) || (13'(bis_ff) < bps_ff), "sample byte count overrun")

endmodule
`default_nettype wire

// ===== rtl/wrsp_out_stage.sv =====
`default_nettype none
`include "wav_riff_stream_parser_core_macros.svh"
module wrsp_out_stage
   import wrsp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          res_valid,
   input  wire rsp_item_type  res_item,
   output logic              item_ready,
   output logic              rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_item_type      rsp_item
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         take;

   assign take       = out_valid_ff && rsp_ready;
   assign item_ready = !skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_item   = out_item_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         // input is held off while the skid entry is full
         if (take) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_item_in  = res_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in  = res_item;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   `WRSP_ASSERT(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid full with output empty")
   `WRSP_ASSERT_NEXT(a_stall_fills_skid, clock, reset, res_valid && !skid_valid_ff && out_valid_ff && !rsp_ready, skid_valid_ff, "stalled item lost")

endmodule
`default_nettype wire

// ===== rtl/wav_riff_stream_parser_core.sv =====
// WAV (RIFF/WAVE PCM) byte-stream parser.
// Input channel req_*: one item per file byte (req_tuser = 0, byte in req_tdata)
// or an end-of-file marker (req_tuser = 1). Result channel rsp_*: at most one
// item per input item; rsp_tuser says format info (0), sample (1) or error (2),
// rsp_tlast marks the final sample of the data chunk.
// The RIFF/WAVE tags are checked, chunks are walked (unknown ones skipped, odd
// bodies padded), the fmt chunk is captured, and at the data chunk one format
// item is sent followed by each sample of every whole frame with its channel index.
// A result is formed combinationally from the byte that completes it and is
// registered in the output register. Throughput: one byte per cycle while
// req_tready is high; all state updates for a byte are made combinationally.
// Stall: a one-entry skid stage backs the output register, so one more byte is
// taken while a result waits; req_tready drops only when the skid entry holds
// a result. Bytes that produce no result pass freely while it is free.
// Reset (synchronous, active high) returns to expecting the RIFF tag and
// empties the output stages. After an error or the end of the samples the
// block swallows all further items until reset.
`default_nettype none
module wav_riff_stream_parser_core
   import wrsp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // [7:0] file_byte
   input  wire logic [0:0]            req_tuser,  // [0] kind
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] channel_count, [47:16] sample_rate, [60:48] bytes_per_sample,
   // [76:61] channel_index, [108:77] sample_value, [111:109] error_code
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                 rsp_tuser,  // [1:0] out_kind
   output logic                       rsp_tlast
);

   logic         in_accept;
   logic         res_valid;
   rsp_item_type res_item;
   rsp_item_type rsp_item;

   assign in_accept = req_tvalid && req_tready;

   wrsp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_accept),
      .item_kind  (req_tuser[0]),
      .item_byte  (req_tdata),
      .res_valid  (res_valid),
      .res_item   (res_item)
   );

   wrsp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_item   (res_item),
      .item_ready (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // pack result fields, error_code highest and channel_count lowest
   assign rsp_tdata = {rsp_item.error_code,
                       rsp_item.sample_value,
                       rsp_item.channel_index,
                       rsp_item.bytes_per_sample,
                       rsp_item.sample_rate,
                       rsp_item.channel_count};
   assign rsp_tuser = rsp_item.out_kind;
   assign rsp_tlast = rsp_item.is_last;

endmodule
`default_nettype wire
